### sv/f2va_pkg.sv
// Package: formats, constants and pipeline types for the float to vertex attribute encoder.
package f2va_pkg;

	typedef enum logic [2:0] {
		FMT_FLOAT32 = 3'd0,
		FMT_UINT8   = 3'd1,
		FMT_INT8    = 3'd2,
		FMT_UINT16  = 3'd3,
		FMT_INT16   = 3'd4
	} fmt_t;

	localparam int FLOAT_W = 32;
	localparam int FMT_W   = 3;
	localparam int SIZE_W  = 3;
	localparam int IN_W    = 40;
	localparam int OUT_W   = 40;

	// Format decode handed from the front stage to the back stages
	typedef struct packed {
		logic       is_float;
		logic       is_int;
		logic       is_signed;
		logic       is_wide;
		logic       norm;
		logic [2:0] size;
	} fmt_ctl_t;

endpackage

### sv/float_to_vertex_attribute_format.sv
// Top level: float32 to vertex attribute encoder with stream ports.
//   channel | direction | handshake       | payload
//   s_axis  | in        | tvalid/tready   | float_bits, format_code, normalise
//   m_axis  | out       | tvalid/tready   | encoded_bits, byte_size, supported
// One item a cycle while the output does not stall, through a five-stage pipeline.
// The whole pipeline holds on an output stall, so nothing is lost or repeated.
// arst_n clears the valid bits only.
module float_to_vertex_attribute_format (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // float_bits[31:0], format_code[34:32], normalise[35]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata   // encoded_bits[31:0], byte_size[34:32], supported[35]
);
	import f2va_pkg::*;

	localparam int DEPTH = 5;

	logic       en;
	logic [DEPTH-1:0] vld_q;
	fmt_ctl_t   ctl_w;
	logic [2:0] fmt_w;
	logic [15:0] fix_w;

	assign en = !vld_q[DEPTH-1] || m_axis_tready;
	assign s_axis_tready = en;

	// Decode the format code
	always_comb begin
		fmt_w = s_axis_tdata[34:32];
		ctl_w = '0;
		ctl_w.norm = s_axis_tdata[35];
		unique case (fmt_w)
			FMT_FLOAT32: begin ctl_w.is_float = 1'b1; ctl_w.size = 3'd4; end
			FMT_UINT8:   begin ctl_w.is_int = 1'b1; ctl_w.size = 3'd1; end
			FMT_INT8:    begin ctl_w.is_int = 1'b1; ctl_w.is_signed = 1'b1;
				ctl_w.size = 3'd1; end
			FMT_UINT16:  begin ctl_w.is_int = 1'b1; ctl_w.is_wide = 1'b1;
				ctl_w.size = 3'd2; end
			FMT_INT16:   begin ctl_w.is_int = 1'b1; ctl_w.is_wide = 1'b1;
				ctl_w.is_signed = 1'b1; ctl_w.size = 3'd2; end
			default: ;
		endcase
	end

	f2va_fix u_fix (
		.clk        (clk),
		.en         (en),
		.float_bits (s_axis_tdata[31:0]),
		.ctl_in     (ctl_w),
		.result     (fix_w)
	);

	// Carry the pass-through word and the decode alongside the datapath
	logic [31:0] bits_q [DEPTH];
	fmt_ctl_t    ctl_q  [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			bits_q[0] <= s_axis_tdata[31:0];
			ctl_q[0]  <= ctl_w;
			for (int i = 1; i < DEPTH; i++) begin
				bits_q[i] <= bits_q[i-1];
				ctl_q[i]  <= ctl_q[i-1];
			end
		end
	end

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], s_axis_tvalid};
		end
	end

	// Select the result word
	logic [31:0] enc_w;
	fmt_ctl_t    co_w;
	always_comb begin
		co_w = ctl_q[DEPTH-1];
		if (co_w.is_float)
			enc_w = bits_q[DEPTH-1];
		else if (co_w.is_int)
			enc_w = {16'd0, fix_w};
		else
			enc_w = 32'd0;
	end

	assign m_axis_tvalid = vld_q[DEPTH-1];

	// Pack the result item from the last stage
	assign m_axis_tdata = {4'd0, co_w.is_float | co_w.is_int, co_w.size, enc_w};

endmodule

### sv/f2va_fix.sv
// Module: fixed-point conversion of a float32 value into a clamped, scaled and rounded integer.
module f2va_fix (
	input  logic                   clk,
	input  logic                   en,
	input  logic [31:0]            float_bits,
	input  f2va_pkg::fmt_ctl_t     ctl_in,
	output logic [15:0]            result
);
	import f2va_pkg::*;

	// Stage 1: unpack and classify
	logic        sign_s1, nan_s1, big_s1, zero_s1;
	logic [23:0] mant_s1;
	logic [7:0]  exp_s1;
	fmt_ctl_t    ctl_s1;

	logic [7:0]  e_w;
	logic [22:0] f_w;
	assign e_w = float_bits[30:23];
	assign f_w = float_bits[22:0];

	always_ff @(posedge clk) begin
		if (en) begin
			sign_s1 <= float_bits[31];
			nan_s1  <= (e_w == 8'hFF) && (f_w != 23'd0);
			// at or above 2^17 the value is clamped anyway
			big_s1  <= (e_w >= 8'd144);
			// below 2^-17 every format rounds to zero, scaled or not
			zero_s1 <= (e_w < 8'd110);
			mant_s1 <= {1'b1, f_w};
			exp_s1  <= e_w;
			ctl_s1  <= ctl_in;
		end
	end

	// Stage 2: build |v| as fixed point with 17 integer and 40 fraction bits
	// (exact for every value from 2^-17 up to 2^17)
	logic [56:0] mag_s2;
	logic        sign_s2, nan_s2, big_s2;
	fmt_ctl_t    ctl_s2;
	logic [56:0] shl_w;
	logic [5:0]  sh_w;

	always_comb begin
		sh_w  = 6'(exp_s1 - 8'd110);
		shl_w = {33'd0, mant_s1} << sh_w;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// 2^(e-127) * m/2^23 * 2^40 = m << (e-110)
			mag_s2  <= (zero_s1 || big_s1) ? 57'd0 : shl_w;
			sign_s2 <= sign_s1;
			nan_s2  <= nan_s1;
			big_s2  <= big_s1;
			ctl_s2  <= ctl_s1;
		end
	end

	// Stage 3: clamp in magnitude (negatives to zero for unsigned), then pick the scale for normalised formats
	logic [56:0] lim_w, cl_w;
	logic        over_w;
	logic [15:0] scale_w;
	logic        neg_ok_w;

	always_comb begin
		neg_ok_w = ctl_s2.is_signed;
		if (ctl_s2.norm)
			lim_w = 57'd1 << 40;
		else if (ctl_s2.is_signed)
			lim_w = (ctl_s2.is_wide ? 57'd32767 : 57'd127) << 40;
		else
			lim_w = (ctl_s2.is_wide ? 57'd65535 : 57'd255) << 40;
		// signed raw clamp allows one more step on the negative side
		if (sign_s2 && ctl_s2.is_signed && !ctl_s2.norm)
			lim_w = lim_w + (57'd1 << 40);
		over_w = big_s2 || (mag_s2 > lim_w);
		cl_w   = over_w ? lim_w : mag_s2;
		if (sign_s2 && !neg_ok_w)
			cl_w = 57'd0;
		unique case ({ctl_s2.is_signed, ctl_s2.is_wide})
			2'b00:   scale_w = 16'd255;
			2'b01:   scale_w = 16'd65535;
			2'b10:   scale_w = 16'd127;
			default: scale_w = 16'd32767;
		endcase
	end

	logic [40:0] frac_s3;
	logic [56:0] raw_s3;
	logic [15:0] scale_s3;
	logic        sign_s3, nan_s3;
	fmt_ctl_t    ctl_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			frac_s3  <= cl_w[40:0];
			raw_s3   <= cl_w;
			scale_s3 <= scale_w;
			sign_s3  <= sign_s2;
			nan_s3   <= nan_s2;
			ctl_s3   <= ctl_s2;
		end
	end

	// Stage 4: multiply the unit value (41 bits at most) by the scale
	logic [56:0] prod_s4;
	logic [56:0] raw_s4;
	logic        sign_s4, nan_s4;
	fmt_ctl_t    ctl_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s4 <= 57'(frac_s3 * scale_s3);
			raw_s4  <= raw_s3;
			sign_s4 <= sign_s3;
			nan_s4  <= nan_s3;
			ctl_s4  <= ctl_s3;
		end
	end

	// Stage 5: round the float32 product, then round half away, apply sign
	// product has 40 fraction bits; float32 keeps 24 significant bits
	logic [56:0] p_w, keep_w, half_w, rem_w;
	logic [5:0]  msb_w;
	logic [5:0]  drop_w;
	logic [56:0] fx_w;
	logic [16:0] mag_w;
	logic [16:0] sres_w;

	always_comb begin
		p_w   = prod_s4;
		msb_w = 6'd0;
		for (int i = 0; i < 57; i++)
			if (p_w[i]) msb_w = 6'(i);
		drop_w = (msb_w > 6'd23) ? 6'(msb_w - 6'd23) : 6'd0;
		half_w = (drop_w == 6'd0) ? 57'd0 : (57'd1 << (drop_w - 6'd1));
		keep_w = (p_w >> drop_w) << drop_w;
		rem_w  = p_w - keep_w;
		// round to nearest even at the float32 precision
		if (drop_w != 6'd0 && (rem_w > half_w ||
				(rem_w == half_w && p_w[drop_w])))
			keep_w = keep_w + (57'd1 << drop_w);
		fx_w  = ctl_s4.norm ? keep_w : raw_s4;
		mag_w = 17'(fx_w[56:40]) + 17'(fx_w[39]);
		sres_w = sign_s4 ? 17'(-mag_w) : mag_w;
	end

	always_ff @(posedge clk) begin
		if (en)
			result <= nan_s4 ? 16'd0 :
				(ctl_s4.is_wide ? sres_w[15:0] : {8'd0, sres_w[7:0]});
	end

endmodule
